[design/lse_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lse_pkg;

	// fixed field widths
	localparam int MASK_W   = 62;
	localparam int CNT_W    = 6;
	localparam int ENERGY_W = 17;
	localparam int SQ_W     = 12;

	localparam int SPIN_COUNT_RESET = 10;
	localparam logic [ENERGY_W-1:0] ENERGY_MAX = ENERGY_W'(77531);

	// data handed from one cell to the next
	typedef struct packed {
		logic                valid;
		logic [MASK_W-1:0]   mask;
		logic [ENERGY_W-1:0] acc;
		logic [CNT_W-1:0]    diff;
		logic [CNT_W-1:0]    pairs;
	} lse_link_t;

	// population count as an adder tree, one level per loop
	function automatic logic [CNT_W-1:0] popcount(input logic [MASK_W-1:0] v);
		logic [63:0] a;
		logic [1:0]  l1 [32];
		logic [2:0]  l2 [16];
		logic [3:0]  l3 [8];
		logic [4:0]  l4 [4];
		logic [5:0]  l5 [2];
		logic [6:0]  l6;
		a = {2'b00, v};
		for (int i = 0; i < 32; i++) l1[i] = {1'b0, a[2*i]} + {1'b0, a[2*i+1]};
		for (int i = 0; i < 16; i++) l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
		for (int i = 0; i < 8; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
		for (int i = 0; i < 4; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
		for (int i = 0; i < 2; i++)  l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
		l6 = {1'b0, l5[0]} + {1'b0, l5[1]};
		return l6[CNT_W-1:0];
	endfunction

	// squared autocorrelation of one lag: (pairs - 2*differ)^2
	function automatic logic [SQ_W-1:0] lag_term(input logic [CNT_W-1:0] pairs,
		input logic [CNT_W-1:0] diff);
		logic signed [7:0]  c;
		logic signed [15:0] sq;
		c  = $signed({2'b00, pairs}) - $signed({1'b0, diff, 1'b0});
		sq = c * c;
		return sq[SQ_W-1:0];
	endfunction

endpackage

`default_nettype wire

[design/lse_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module lse_cell
	import lse_pkg::*;
#(
	parameter int LAG = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             enable,
	input  wire logic [CNT_W-1:0] n,
	input  wire logic [MASK_W-1:0] n_mask,
	input  wire lse_link_t        link_i,
	output lse_link_t             link_o
);

	logic [MASK_W-1:0]   pair_mask;
	logic [CNT_W-1:0]    diff_d;
	logic [CNT_W-1:0]    pairs_d;
	logic [ENERGY_W-1:0] acc_d;

	logic                valid_q;
	logic [MASK_W-1:0]   mask_q;
	logic [ENERGY_W-1:0] acc_q;
	logic [CNT_W-1:0]    diff_q;
	logic [CNT_W-1:0]    pairs_q;

	// differing pairs at this lag, only positions with a partner below n
	always_comb begin
		pair_mask = n_mask >> LAG;
		diff_d    = popcount((link_i.mask ^ (link_i.mask >> LAG)) & pair_mask);
		pairs_d   = (n > CNT_W'(LAG)) ? (n - CNT_W'(LAG)) : '0;
	end

	// fold in the previous lag's squared term
	assign acc_d = link_i.acc + ENERGY_W'(lag_term(link_i.pairs, link_i.diff));

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (enable) begin
			valid_q <= link_i.valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (enable) begin
			mask_q  <= link_i.mask;
			acc_q   <= acc_d;
			diff_q  <= diff_d;
			pairs_q <= pairs_d;
		end
	end

	assign link_o = '{valid: valid_q, mask: mask_q, acc: acc_q, diff: diff_q, pairs: pairs_q};

endmodule

`default_nettype wire

[design/lse_out.sv]
`timescale 1ns / 1ps
`default_nettype none

module lse_out
	import lse_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire lse_link_t           link_i,
	input  wire logic                result_stall,
	output logic                     result_valid,
	output logic [ENERGY_W-1:0]      energy,
	output logic                     enable
);

	logic [ENERGY_W-1:0] energy_d;
	logic                take;

	logic                out_valid_q;
	logic [ENERGY_W-1:0] out_energy_q;
	logic                skid_valid_q;
	logic [ENERGY_W-1:0] skid_energy_q;

	// last lag's term
	assign energy_d = link_i.acc + ENERGY_W'(lag_term(link_i.pairs, link_i.diff));

	assign take   = out_valid_q & ~result_stall;
	assign enable = ~skid_valid_q;

	// output register and skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (link_i.valid) begin
			if (out_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_energy_q <= skid_energy_q;
			end
		end else if (link_i.valid) begin
			if (out_valid_q && !take) begin
				skid_energy_q <= energy_d;
			end else begin
				out_energy_q <= energy_d;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign energy       = out_energy_q;

endmodule

`default_nettype wire

[design/labs_sidelobe_energy_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// LABS sidelobe energy. Each transfer on the item channel carries a spin mask
// (bit i set is spin +1, clear is -1); the block returns the sum over lags
// 1..n-1 of the squared aperiodic autocorrelation, with n from the spin_count
// register (reset 10, values above MAX_SPINS read as MAX_SPINS, 0 and 1 give
// energy 0). One item is taken per clock while item_stall is low; the result
// passes through the input register, the row of one cell per lag and the
// output register. An output register and a skid entry let the row keep
// taking items while a result waits; item_stall rises only when both are
// full. Write spin_count only while no item is in flight.
module labs_sidelobe_energy_top
	import lse_pkg::*;
#(
	parameter int MAX_SPINS = 62
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wr_en,
	input  wire logic [CNT_W-1:0]    cfg_wr_data,
	input  wire logic                item_valid,
	output logic                     item_stall,
	input  wire logic [MASK_W-1:0]   spin_mask,
	output logic                     result_valid,
	input  wire logic                result_stall,
	output logic [ENERGY_W-1:0]      energy
);

	localparam logic [CNT_W-1:0] N_MAX = CNT_W'(MAX_SPINS);
	localparam logic [CNT_W-1:0] N_RESET =
		CNT_W'((MAX_SPINS < SPIN_COUNT_RESET) ? MAX_SPINS : SPIN_COUNT_RESET);

	logic [CNT_W-1:0]  n_q;
	logic [MASK_W-1:0] n_mask;
	logic              enable;
	logic              in_valid_q;
	logic [MASK_W-1:0] in_mask_q;
	lse_link_t         link [MAX_SPINS];

	// spin count register, saturated on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= N_RESET;
		end else if (cfg_wr_en) begin
			n_q <= (cfg_wr_data > N_MAX) ? N_MAX : cfg_wr_data;
		end
	end

	// ones in the low n bits
	assign n_mask = {MASK_W{1'b1}} >> (7'(MASK_W) - {1'b0, n_q});

	assign item_stall = ~enable;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_q <= 1'b0;
		end else if (enable) begin
			in_valid_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (enable) begin
			in_mask_q <= spin_mask & n_mask;
		end
	end

	assign link[0] = '{valid: in_valid_q, mask: in_mask_q, acc: '0, diff: '0, pairs: '0};

	// one cell per lag
	for (genvar k = 1; k < MAX_SPINS; k++) begin : g_cell
		lse_cell #(
			.LAG(k)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.enable (enable),
			.n      (n_q),
			.n_mask (n_mask),
			.link_i (link[k-1]),
			.link_o (link[k])
		);
	end

	lse_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.link_i       (link[MAX_SPINS-1]),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.energy       (energy),
		.enable       (enable)
	);

endmodule

`default_nettype wire

[design/lse_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module lse_checker
	import lse_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                item_stall,
	input wire logic                result_valid,
	input wire logic                result_stall,
	input wire logic [ENERGY_W-1:0] energy
);

	// a stalled result stays offered
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its value
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(energy))
		else $error("energy changed while stalled");

	// energy never exceeds the largest possible sum
	a_energy_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> energy <= ENERGY_MAX)
		else $error("energy out of range");

	// input side backs up only behind a waiting, stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && $past(result_valid && result_stall))
		else $error("item stall without a blocked result");

endmodule

bind labs_sidelobe_energy_top lse_checker u_lse_checker (.*);

`default_nettype wire

[sim/tb_labs_sidelobe_energy_top.sv]
`timescale 1ns / 1ps

module tb_labs_sidelobe_energy_top;
	import lse_pkg::*;

	localparam int SPIN_LIMIT = 62;
	localparam int HOLD_CYCLES = 400;
	localparam int RUN_LIMIT = 200000;
	localparam int SEGMENT_ITEMS = 118;
	localparam logic [MASK_W-1:0] ALL_ONES = '1;
	localparam logic [MASK_W-1:0] ALT_SPINS = {31{2'b01}};
	// length-13 barker code, spin i in bit i, energy 6
	localparam logic [MASK_W-1:0] BARKER13 = 62'h159F;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CNT_W-1:0] cfg_wr_data = '0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [MASK_W-1:0] spin_mask = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [ENERGY_W-1:0] energy;

	// predictor state and bookkeeping
	logic [CNT_W-1:0] spin_cnt = CNT_W'(SPIN_COUNT_RESET);
	logic [ENERGY_W-1:0] energy_due[$];
	int n_checked = 0;
	int n_errors = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int cycle_count = 0;

	// long receiver hold-off request, toggled by a test
	logic hold_go = 1'b0;
	logic hold_seen = 1'b0;
	int hold_left = 0;

	labs_sidelobe_energy_top #(
		.MAX_SPINS(SPIN_LIMIT)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.spin_mask   (spin_mask),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.energy      (energy)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// sum of squared aperiodic autocorrelations over lags 1..n-1
	function automatic logic [ENERGY_W-1:0] sidelobe_energy(input logic [MASK_W-1:0] m,
		input logic [CNT_W-1:0] cnt);
		int n;
		int pairs;
		int differ;
		int c;
		int unsigned e;
		n = (int'(cnt) > SPIN_LIMIT) ? SPIN_LIMIT : int'(cnt);
		e = 0;
		for (int k = 1; k < n; k++) begin
			pairs = n - k;
			differ = 0;
			for (int i = 0; i < pairs; i++) begin
				if (m[i] != m[i+k])
					differ++;
			end
			c = pairs - 2 * differ;
			e += c * c;
		end
		return e[ENERGY_W-1:0];
	endfunction

	function automatic logic [MASK_W-1:0] rand_word();
		return MASK_W'({$urandom, $urandom});
	endfunction

	// mostly uniform masks, some sparse, dense or near the barker code
	function automatic logic [MASK_W-1:0] rand_spins();
		int pick;
		logic [MASK_W-1:0] m;
		pick = $urandom_range(99);
		if (pick < 60)
			m = rand_word();
		else if (pick < 75)
			m = rand_word() & rand_word() & rand_word();
		else if (pick < 90)
			m = rand_word() | rand_word() | rand_word();
		else
			m = (rand_word() & ~MASK_W'(62'h1FFF))
				| (BARKER13 ^ (MASK_W'(1) << $urandom_range(12)));
		return m;
	endfunction

	// receiver side: random stall, or a counted hold-off when requested
	always @(negedge clk) begin
		if (hold_go != hold_seen) begin
			hold_seen <= hold_go;
			hold_left <= HOLD_CYCLES;
			result_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// compare each result transfer with the oldest predicted energy
	always @(posedge clk) begin : check_results
		logic [ENERGY_W-1:0] want;
		if (arst_n && result_valid && !result_stall) begin
			if (energy_due.size() == 0) begin
				$error("energy: result with none expected, actual %0d", energy);
				n_errors++;
			end else begin
				want = energy_due[0];
				energy_due.delete(0);
				n_checked++;
				if (energy !== want) begin
					$error("energy: expected %0d, actual %0d", want, energy);
					n_errors++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > RUN_LIMIT) begin
			$display("tb_labs_sidelobe_energy_top: done, errors");
			$finish;
		end
	end

	// offer one mask until it transfers; entered and left at a falling edge
	task automatic send_mask(input logic [MASK_W-1:0] m);
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		spin_mask <= m;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		energy_due = {energy_due, sidelobe_energy(m, spin_cnt)};
		@(negedge clk);
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (energy_due.size() != 0)
			@(negedge clk);
		repeat (SPIN_LIMIT + 4) @(negedge clk);
	endtask

	task automatic set_spin_count(input logic [CNT_W-1:0] v);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		spin_cnt = v;
	endtask

	task automatic test_reset_count();
		send_mask('0);
		send_mask(ALL_ONES);
		send_mask(ALT_SPINS);
	endtask

	task automatic test_mask_extremes();
		set_spin_count(CNT_W'(SPIN_LIMIT));
		send_mask('0);
		send_mask(ALL_ONES);
		send_mask(ALT_SPINS);
		send_mask(~ALT_SPINS);
		send_mask(MASK_W'(1));
		send_mask(MASK_W'(1) << (MASK_W - 1));
	endtask

	// no lag for 0 or 1 spins, 63 saturates, 2 is the shortest sequence
	task automatic test_spin_count_edges();
		set_spin_count(CNT_W'(0));
		send_mask(ALL_ONES);
		send_mask(rand_word());
		set_spin_count(CNT_W'(1));
		send_mask(ALL_ONES);
		send_mask(rand_word());
		set_spin_count('1);
		send_mask(ALL_ONES);
		send_mask(rand_word());
		set_spin_count(CNT_W'(2));
		send_mask(ALL_ONES & ~MASK_W'(2));
		send_mask(ALL_ONES);
	endtask

	// upper mask bits must be ignored
	task automatic test_barker();
		set_spin_count(CNT_W'(13));
		send_mask(BARKER13);
		send_mask(BARKER13 | (ALL_ONES << 13));
	endtask

	task automatic run_segment(input logic [CNT_W-1:0] cnt, input int n_items);
		set_spin_count(cnt);
		repeat (n_items) send_mask(rand_spins());
	endtask

	task automatic test_random_traffic();
		int idle_mix[4];
		int stall_mix[4];
		logic [CNT_W-1:0] edge_cnt[4];
		idle_mix = '{0, 72, 0, 21};
		stall_mix = '{0, 0, 72, 21};
		edge_cnt = '{CNT_W'(2), CNT_W'(SPIN_LIMIT), '1, CNT_W'(1)};
		for (int p = 0; p < 4; p++) begin
			idle_pct = idle_mix[p];
			stall_pct = stall_mix[p];
			run_segment(CNT_W'($urandom_range(SPIN_LIMIT, 2)), SEGMENT_ITEMS);
			run_segment(CNT_W'($urandom_range(12, 2)), SEGMENT_ITEMS);
			run_segment(edge_cnt[p], SEGMENT_ITEMS);
		end
		idle_pct = 0;
		stall_pct = 0;
	endtask

	// receiver holds off while the sender keeps going, so the row fills up
	task automatic test_output_backpressure();
		set_spin_count(CNT_W'($urandom_range(SPIN_LIMIT, 40)));
		idle_pct = 0;
		stall_pct = 0;
		hold_go <= ~hold_go;
		repeat (120) send_mask(rand_spins());
		wait_drained();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_count();
		test_mask_extremes();
		test_spin_count_edges();
		test_barker();
		test_random_traffic();
		test_output_backpressure();
		wait_drained();

		$display("checked %0d energy transfers over spin counts 0..63 incl. saturation,",
			n_checked);
		$display("four sender/receiver idle mixes and a %0d-cycle receiver hold-off",
			HOLD_CYCLES);
		if (n_errors == 0)
			$display("tb_labs_sidelobe_energy_top: done, clean");
		else
			$display("tb_labs_sidelobe_energy_top: done, errors");
		$finish;
	end

endmodule

[files.f]
design/lse_pkg.sv
design/lse_cell.sv
design/lse_out.sv
design/labs_sidelobe_energy_top.sv
design/lse_checker.sv
sim/tb_labs_sidelobe_energy_top.sv
